[hw/rtl/sorted_integer_set_engine_unit_defines.svh]
// assertion macros for the sorted integer set engine checker
// depends on clk and arst_n being visible where the macros are used
`ifndef SORTED_INTEGER_SET_ENGINE_UNIT_DEFINES_SVH
`define SORTED_INTEGER_SET_ENGINE_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define SIS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sis_pkg.sv]
// shared types and constants of the sorted integer set engine
// no dependencies
package sis_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		FUNC_ADD    = 3'd0,
		FUNC_REMOVE = 3'd1,
		FUNC_LIST   = 3'd2,
		FUNC_UNION  = 3'd3,
		FUNC_INTER  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		KIND_LISTED  = 3'd0,
		KIND_INSERT  = 3'd1,
		KIND_PRESENT = 3'd2,
		KIND_REMOVED = 3'd3,
		KIND_ABSENT  = 3'd4,
		KIND_FULL    = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD,
		ST_WALK
	} state_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      inc;
		logic      dec;
	} chain_ctrl_t;

endpackage

[hw/rtl/sis_cell.sv]
// one storage cell of a set chain: holds one entry and its compare flags
// depends on sis_pkg
module sis_cell #(
	parameter int INDEX = 0,
	parameter int CW = 6
) (
	input  logic                              clk,
	input  sis_pkg::cell_cmd_t                cmd,
	input  logic [CW-1:0]                     count,
	input  logic signed [sis_pkg::DATA_W-1:0] value,
	input  logic signed [sis_pkg::DATA_W-1:0] left_entry,
	input  logic                              left_after,
	input  logic signed [sis_pkg::DATA_W-1:0] right_entry,
	input  logic signed [sis_pkg::DATA_W-1:0] head_entry,
	output logic signed [sis_pkg::DATA_W-1:0] entry_q,
	output logic                              after_q,
	output logic                              eq_q
);
	import sis_pkg::*;

	logic in_range;
	logic is_tail;
	logic past_q;

	assign in_range = count > CW'(INDEX);
	assign is_tail  = count == CW'(INDEX + 1);

	// compare flags and entry movement
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_CMP: begin
				eq_q    <= in_range && (entry_q == value);
				after_q <= !in_range || (value < entry_q);
				past_q  <= in_range && !(entry_q < value);
			end
			CELL_INSERT: begin
				if (left_after)
					entry_q <= left_entry;
				else if (after_q)
					entry_q <= value;
			end
			CELL_DELETE: begin
				if (past_q)
					entry_q <= right_entry;
			end
			CELL_ROTATE: begin
				entry_q <= is_tail ? head_entry : right_entry;
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/sis_chain.sv]
// one set: a row of cells plus its count register
// depends on sis_pkg and sis_cell
module sis_chain #(
	parameter int CAPACITY = sis_pkg::CAPACITY_DEF,
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sis_pkg::chain_ctrl_t              ctrl,
	input  logic signed [sis_pkg::DATA_W-1:0] value,
	output logic signed [sis_pkg::DATA_W-1:0] head,
	output logic [CW-1:0]                     count,
	output logic                              found,
	output logic                              full
);
	import sis_pkg::*;

	logic signed [DATA_W-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0]      after_vec;
	logic [CAPACITY-1:0]      eq_vec;
	logic [CW-1:0]            count_q;

	// cell row, each wired to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_e;
		logic signed [DATA_W-1:0] right_e;
		logic                     left_a;
		if (i == 0) begin : g_first
			assign left_e = entry[0];
			assign left_a = 1'b0;
		end else begin : g_mid
			assign left_e = entry[i-1];
			assign left_a = after_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_e = entry[i];
		end else begin : g_inner
			assign right_e = entry[i+1];
		end
		sis_cell #(.INDEX(i), .CW(CW)) u_cell (
			.clk        (clk),
			.cmd        (ctrl.cmd),
			.count      (count_q),
			.value      (value),
			.left_entry (left_e),
			.left_after (left_a),
			.right_entry(right_e),
			.head_entry (entry[0]),
			.entry_q    (entry[i]),
			.after_q    (after_vec[i]),
			.eq_q       (eq_vec[i])
		);
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.inc) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign head  = entry[0];
	assign count = count_q;
	assign found = |eq_vec;
	assign full  = count_q == CW'(CAPACITY);

endmodule

[hw/rtl/sorted_integer_set_engine_unit.sv]
// channel | direction | handshake          | payload
// request | in        | in_valid, in_stall | func, set_select, value
// result  | out       | out_valid, out_stall | kind, element, last
// add and remove: after accept, compare in every cell, then shift the row in
// place while the status beat is loaded; the next request can be taken while
// that status beat is on the output.
// list, union and intersection walk the chains one rotation per cycle while the
// output is free; a held-back beat waits for the next emitted element or the end.
// arst_n clears counts and control; entries are undefined until written.
// a stall on the result side freezes the walk; requests wait in between.
module sorted_integer_set_engine_unit #(
	parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        func,
	input  logic                              set_select,
	input  logic signed [sis_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        kind,
	output logic signed [sis_pkg::DATA_W-1:0] element,
	output logic                              last
);
	import sis_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	func_t  func_q;
	logic   sel_q;
	logic   a_sel_q;
	logic signed [DATA_W-1:0] value_q;
	logic [CW-1:0] ia_q, jb_q, na_q, nb_q;
	logic pend_q;
	logic signed [DATA_W-1:0] pend_elem_q;
	logic out_valid_q, last_q;
	logic [2:0] kind_q;
	logic signed [DATA_W-1:0] element_q;

	chain_ctrl_t ctrl [2];
	logic signed [DATA_W-1:0] head [2];
	logic [CW-1:0] cnt [2];
	logic found [2];
	logic full [2];

	logic out_free, accept;
	logic a_ok, b_ok, take_a, take_b, emit, done;
	logic signed [DATA_W-1:0] ha, hb, emit_val;
	logic sel_found, sel_full;

	for (genvar k = 0; k < 2; k++) begin : g_chain
		sis_chain #(.CAPACITY(CAPACITY), .CW(CW)) u_chain (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl[k]),
			.value (value_q),
			.head  (head[k]),
			.count (cnt[k]),
			.found (found[k]),
			.full  (full[k])
		);
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign sel_found = found[sel_q];
	assign sel_full  = full[sel_q];

	// merge step decision
	assign ha   = head[a_sel_q];
	assign hb   = head[1];
	assign a_ok = ia_q != na_q;
	assign b_ok = jb_q != nb_q;
	assign done = !a_ok && !b_ok;
	always_comb begin
		take_a   = 1'b0;
		take_b   = 1'b0;
		emit     = 1'b0;
		emit_val = ha;
		if (func_q == FUNC_INTER) begin
			if (a_ok && b_ok) begin
				take_a = !(hb < ha);
				take_b = !(ha < hb);
				emit   = ha == hb;
			end else begin
				take_a = a_ok;
				take_b = b_ok;
			end
		end else begin
			take_a   = a_ok && (!b_ok || !(hb < ha));
			take_b   = b_ok && (!a_ok || !(ha < hb));
			emit     = a_ok || b_ok;
			emit_val = take_a ? ha : hb;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and chain commands
	always_comb begin
		state_d = state_q;
		for (int k = 0; k < 2; k++)
			ctrl[k] = '{cmd: CELL_HOLD, inc: 1'b0, dec: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_ADD, FUNC_REMOVE: state_d = ST_CMP;
						FUNC_LIST, FUNC_UNION, FUNC_INTER: state_d = ST_WALK;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CMP: begin
				ctrl[sel_q].cmd = CELL_CMP;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					state_d = ST_IDLE;
					if (func_q == FUNC_ADD && !sel_found && !sel_full) begin
						ctrl[sel_q].cmd = CELL_INSERT;
						ctrl[sel_q].inc = 1'b1;
					end else if (func_q == FUNC_REMOVE && sel_found) begin
						ctrl[sel_q].cmd = CELL_DELETE;
						ctrl[sel_q].dec = 1'b1;
					end
				end
			end
			ST_WALK: begin
				if (out_free) begin
					if (done) begin
						state_d = ST_IDLE;
					end else begin
						if (take_a)
							ctrl[a_sel_q].cmd = CELL_ROTATE;
						if (take_b)
							ctrl[1].cmd = CELL_ROTATE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// request latch and walk counters
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(func);
			sel_q   <= set_select;
			value_q <= value;
			a_sel_q <= (func == FUNC_LIST) ? set_select : 1'b0;
			na_q    <= (func == FUNC_LIST) ? cnt[set_select] : cnt[0];
			nb_q    <= (func == FUNC_LIST) ? CW'(0) : cnt[1];
			ia_q    <= '0;
			jb_q    <= '0;
		end else if (state_q == ST_WALK && out_free && !done) begin
			if (take_a)
				ia_q <= ia_q + CW'(1);
			if (take_b)
				jb_q <= jb_q + CW'(1);
		end
	end

	// held-back element, so the final beat can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (state_q == ST_WALK && out_free) begin
			if (done)
				pend_q <= 1'b0;
			else if (emit)
				pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && out_free && !done && emit)
			pend_elem_q <= emit_val;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_UPD) ||
				(state_q == ST_WALK && pend_q && (done || emit));
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_UPD) begin
				element_q <= value_q;
				last_q    <= 1'b1;
				if (func_q == FUNC_ADD)
					kind_q <= sel_found ? KIND_PRESENT : (sel_full ? KIND_FULL : KIND_INSERT);
				else
					kind_q <= sel_found ? KIND_REMOVED : KIND_ABSENT;
			end else begin
				element_q <= pend_elem_q;
				last_q    <= done;
				kind_q    <= KIND_LISTED;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

[hw/rtl/sis_checker.sv]
// port-level checks for the sorted integer set engine, bound to the top level
// depends on sis_pkg and sorted_integer_set_engine_unit_defines.svh
`include "sorted_integer_set_engine_unit_defines.svh"

module sis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  func,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic [31:0] element,
	input logic        last
);
	import sis_pkg::*;

	// a stalled result beat holds
	`SIS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(element) && $stable(kind) && $stable(last), "stalled result beat changed")
	// one request at a time; unused codes finish at once
	`SIS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && func <= FUNC_INTER, in_stall, "request taken while busy")
	// status beats are always the final beat
	`SIS_ASSERT_IMP(a_status_last, out_valid && kind != KIND_LISTED, last, "status beat without last")
	// only defined result kinds
	`SIS_ASSERT_IMP(a_kind_range, out_valid, kind <= KIND_FULL, "undefined result kind")

endmodule

bind sorted_integer_set_engine_unit sis_checker u_sis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.func     (func),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.kind     (kind),
	.element  (element),
	.last     (last)
);
